@@ rtl/core/rae_pkg.sv @@
// Shared types and constants for the R-type execute block
package rae_pkg;

    localparam int DATA_W        = 32;
    localparam int IDX_FIELD_W   = 5;
    localparam int ACT_W         = 4;
    localparam int STATUS_W      = 2;
    localparam int REG_COUNT_DEF = 32;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NOR  = 4'd0;
    localparam logic [ACT_W-1:0] ACT_OR   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_XOR  = 4'd2;
    localparam logic [ACT_W-1:0] ACT_AND  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_NAND = 4'd4;
    localparam logic [ACT_W-1:0] ACT_SLT  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_JR   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_SLL  = 4'd7;
    localparam logic [ACT_W-1:0] ACT_SRL  = 4'd8;
    localparam logic [ACT_W-1:0] ACT_SRA  = 4'd9;
    localparam logic [ACT_W-1:0] ACT_ADD  = 4'd10;
    localparam logic [ACT_W-1:0] ACT_SUB  = 4'd11;
    localparam logic [ACT_W-1:0] ACT_LOAD = 4'd12;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_NORMAL    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SKIP_ZERO = 2'd2;

    // Subtrahend that always flags overflow on sub
    localparam logic [DATA_W-1:0] SUB_OVF_VALUE = 32'h8000_0000;

    // Register file write request
    typedef struct packed {
        logic                   en;
        logic [IDX_FIELD_W-1:0] addr;
        logic [DATA_W-1:0]      data;
    } rf_wr_t;

    // Execute result
    typedef struct packed {
        logic [DATA_W-1:0]   result;
        logic                wrote;
        logic [STATUS_W-1:0] status;
        logic                overflow;
        logic [DATA_W-1:0]   next_pc;
    } alu_out_t;

endpackage

@@ rtl/core/rae_regfile.sv @@
// Register file: one write port, two registered read ports, valid bits for reset,
// bypass of a write landing in the same cycle as the read
module rae_regfile #(
    parameter int REG_COUNT = rae_pkg::REG_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [rae_pkg::IDX_FIELD_W-1:0]  rd_addr_a,
    input  logic [rae_pkg::IDX_FIELD_W-1:0]  rd_addr_b,
    input  rae_pkg::rf_wr_t                  wr,
    output logic [rae_pkg::DATA_W-1:0]       op_a,
    output logic [rae_pkg::DATA_W-1:0]       op_b
);

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [rae_pkg::DATA_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0]       vld_reg;

    logic [rae_pkg::DATA_W-1:0] mem_a_reg;
    logic [rae_pkg::DATA_W-1:0] mem_b_reg;
    logic                       live_a_reg;
    logic                       live_b_reg;
    logic                       fwd_a_reg;
    logic                       fwd_b_reg;
    logic [rae_pkg::DATA_W-1:0] fwd_data_reg;

    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_w;
    logic             rng_a;
    logic             rng_b;

    assign idx_a = IDX_W'(rd_addr_a);
    assign idx_b = IDX_W'(rd_addr_b);
    assign idx_w = IDX_W'(wr.addr);
    assign rng_a = 32'(rd_addr_a) < 32'(REG_COUNT);
    assign rng_b = 32'(rd_addr_b) < 32'(REG_COUNT);

    // Storage write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[idx_w] <= wr.data;
        end
    end

    // Entry valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[idx_w] <= 1'b1;
        end
    end

    // Registered reads plus same-cycle write capture
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_a_reg    <= mem[idx_a];
            mem_b_reg    <= mem[idx_b];
            live_a_reg   <= rng_a && vld_reg[idx_a];
            live_b_reg   <= rng_b && vld_reg[idx_b];
            fwd_a_reg    <= wr.en && (wr.addr == rd_addr_a);
            fwd_b_reg    <= wr.en && (wr.addr == rd_addr_b);
            fwd_data_reg <= wr.data;
        end
    end

    // Operand select: bypass, stored value, or zero
    assign op_a = fwd_a_reg  ? fwd_data_reg :
                  live_a_reg ? mem_a_reg    : '0;
    assign op_b = fwd_b_reg  ? fwd_data_reg :
                  live_b_reg ? mem_b_reg    : '0;

endmodule

@@ rtl/core/rae_alu.sv @@
// Operation decode, ALU and write/status decision
module rae_alu #(
    parameter int REG_COUNT = rae_pkg::REG_COUNT_DEF
) (
    input  logic [rae_pkg::ACT_W-1:0]       action,
    input  logic [rae_pkg::IDX_FIELD_W-1:0] dest,
    input  logic [rae_pkg::IDX_FIELD_W-1:0] shift_amount,
    input  logic [rae_pkg::DATA_W-1:0]      load_value,
    input  logic [rae_pkg::DATA_W-1:0]      op_a,
    input  logic [rae_pkg::DATA_W-1:0]      op_b,
    input  logic [rae_pkg::DATA_W-1:0]      pc,
    output rae_pkg::alu_out_t               res
);

    localparam int MSB = rae_pkg::DATA_W - 1;

    logic [rae_pkg::DATA_W-1:0] sum;
    logic [rae_pkg::DATA_W-1:0] diff;
    logic [rae_pkg::DATA_W-1:0] neg_b;
    logic                       add_ovf;
    logic                       sub_ovf;
    logic [rae_pkg::DATA_W-1:0] val;
    logic                       writes;
    logic                       ovf;
    logic [rae_pkg::DATA_W-1:0] pc_new;
    logic                       dest_zero;
    logic                       dest_rng;

    // Adder, subtractor and their overflow rules
    assign sum     = op_a + op_b;
    assign diff    = op_a - op_b;
    assign neg_b   = '0 - op_b;
    assign add_ovf = (op_a[MSB] == op_b[MSB]) && (sum[MSB] != op_a[MSB]);
    assign sub_ovf = (op_b == rae_pkg::SUB_OVF_VALUE) ||
                     ((op_a[MSB] == neg_b[MSB]) && (diff[MSB] != op_a[MSB]));

    // Operation decode
    always_comb
    begin
        val    = '0;
        writes = 1'b1;
        ovf    = 1'b0;
        pc_new = pc;
        unique case (action)
            rae_pkg::ACT_NOR:  val = ~(op_a | op_b);
            rae_pkg::ACT_OR:   val = op_a | op_b;
            rae_pkg::ACT_XOR:  val = op_a ^ op_b;
            rae_pkg::ACT_AND:  val = op_a & op_b;
            rae_pkg::ACT_NAND: val = ~(op_a & op_b);
            rae_pkg::ACT_SLT:  val = rae_pkg::DATA_W'($signed(op_a) < $signed(op_b));
            rae_pkg::ACT_JR:
            begin
                writes = 1'b0;
                pc_new = op_a;
            end
            rae_pkg::ACT_SLL:  val = op_b << shift_amount;
            rae_pkg::ACT_SRL:  val = op_b >> shift_amount;
            rae_pkg::ACT_SRA:  val = $unsigned($signed(op_b) >>> shift_amount);
            rae_pkg::ACT_ADD:
            begin
                val = sum;
                ovf = add_ovf;
            end
            rae_pkg::ACT_SUB:
            begin
                val = diff;
                ovf = sub_ovf;
            end
            rae_pkg::ACT_LOAD: val = load_value;
            default:           writes = 1'b0;
        endcase
    end

    // Destination checks and status
    assign dest_zero = (dest == '0);
    assign dest_rng  = 32'(dest) < 32'(REG_COUNT);

    always_comb
    begin
        res.result   = val;
        res.overflow = ovf;
        res.next_pc  = pc_new;
        res.wrote    = writes && !dest_zero && dest_rng;
        if (writes && dest_zero)
        begin
            res.status = rae_pkg::STAT_SKIP_ZERO;
        end
        else if (writes && ovf)
        begin
            res.status = rae_pkg::STAT_OVERFLOW;
        end
        else
        begin
            res.status = rae_pkg::STAT_NORMAL;
        end
    end

endmodule

@@ rtl/core/rtype_alu_execute.sv @@
// Stages: read stage, then execute stage, whose result is held in the output register.
// Throughput: one request per cycle while results drain; the register file read port sets the read stage.
// A result waiting in the output register lets the read stage fill, but then holds the next request.
// Reset: pipeline empty, program counter zero, all registers read as zero at once
// (per-entry valid bits), so no clearing pass is needed.
module rtype_alu_execute #(
    parameter int REG_COUNT = rae_pkg::REG_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[3:0], src_a[8:4], src_b[13:9], dest[18:14], shift_amount[23:19],
    // load_value[55:24]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[31:0], dest_out[36:32], wrote[37], status[39:38], overflow[40],
    // next_pc[72:41], zero[79:73]
    output logic [79:0] m_axis_tdata
);

    logic in_acc;
    logic a_adv;

    logic                            a_vld_reg;
    logic                            a_vld_next;
    logic [rae_pkg::ACT_W-1:0]       a_action_reg;
    logic [rae_pkg::IDX_FIELD_W-1:0] a_dest_reg;
    logic [rae_pkg::IDX_FIELD_W-1:0] a_shamt_reg;
    logic [rae_pkg::DATA_W-1:0]      a_load_reg;

    logic                            out_vld_reg;
    logic                            out_vld_next;
    rae_pkg::alu_out_t               out_res_reg;
    logic [rae_pkg::IDX_FIELD_W-1:0] out_dest_reg;

    logic [rae_pkg::DATA_W-1:0] pc_reg;
    logic [rae_pkg::DATA_W-1:0] pc_next;

    logic [rae_pkg::DATA_W-1:0] op_a;
    logic [rae_pkg::DATA_W-1:0] op_b;
    rae_pkg::alu_out_t          alu_res;
    rae_pkg::rf_wr_t            rf_wr;

    // Handshake and stage advance
    assign a_adv         = a_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !a_vld_reg || a_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign a_vld_next   = in_acc ? 1'b1 : (a_adv ? 1'b0 : a_vld_reg);
    assign out_vld_next = a_adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_reg);
    assign pc_next      = a_adv ? alu_res.next_pc : pc_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            pc_reg      <= '0;
        end
        else
        begin
            a_vld_reg   <= a_vld_next;
            out_vld_reg <= out_vld_next;
            pc_reg      <= pc_next;
        end
    end

    // Read stage payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_action_reg <= s_axis_tdata[3:0];
            a_dest_reg   <= s_axis_tdata[18:14];
            a_shamt_reg  <= s_axis_tdata[23:19];
            a_load_reg   <= s_axis_tdata[55:24];
        end
    end

    // Register file write from the execute stage
    assign rf_wr.en   = a_adv && alu_res.wrote;
    assign rf_wr.addr = a_dest_reg;
    assign rf_wr.data = alu_res.result;

    rae_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_acc),
        .rd_addr_a (s_axis_tdata[8:4]),
        .rd_addr_b (s_axis_tdata[13:9]),
        .wr        (rf_wr),
        .op_a      (op_a),
        .op_b      (op_b)
    );

    rae_alu #(
        .REG_COUNT (REG_COUNT)
    ) u_alu (
        .action       (a_action_reg),
        .dest         (a_dest_reg),
        .shift_amount (a_shamt_reg),
        .load_value   (a_load_reg),
        .op_a         (op_a),
        .op_b         (op_b),
        .pc           (pc_reg),
        .res          (alu_res)
    );

    // Output register
    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            out_res_reg  <= alu_res;
            out_dest_reg <= a_dest_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0,
                            out_res_reg.next_pc,
                            out_res_reg.overflow,
                            out_res_reg.status,
                            out_res_reg.wrote,
                            out_dest_reg,
                            out_res_reg.result};

    // A write never reports a skipped write to register zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_res_reg.wrote) |-> (out_res_reg.status != rae_pkg::STAT_SKIP_ZERO))
        else $error("write reported together with skipped register zero");

    // Skipped write status only for register zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_res_reg.status == rae_pkg::STAT_SKIP_ZERO)) |-> (out_dest_reg == '0))
        else $error("skip status on nonzero destination");

    // Program counter moves only when a jump register leaves the execute stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != $past(pc_reg)) |-> $past(a_adv && (a_action_reg == rae_pkg::ACT_JR)))
        else $error("program counter changed without jump register");

    // Register file written only when a result is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.en |=> out_vld_reg)
        else $error("register write without a result");

endmodule

@@ bench/tb_rtype_alu_execute.sv @@
module tb_rtype_alu_execute;

    timeunit 1ns;
    timeprecision 1ps;

    import rae_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_PCT     = 14;
    localparam int CALM_FIRST   = 200;
    localparam int CALM_LAST    = 330;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200_000;

    // Action codes the block treats as no-ops
    localparam logic [ACT_W-1:0] ACT_FIRST_UNUSED = ACT_LOAD + 1'b1;
    localparam logic [ACT_W-1:0] ACT_LAST_UNUSED  = '1;

    // Request fields, action in the lowest bits as on s_axis_tdata
    typedef struct packed {
        logic [DATA_W-1:0]      load_value;
        logic [IDX_FIELD_W-1:0] shamt;
        logic [IDX_FIELD_W-1:0] dest;
        logic [IDX_FIELD_W-1:0] src_b;
        logic [IDX_FIELD_W-1:0] src_a;
        logic [ACT_W-1:0]       action;
    } instr_t;

    typedef struct packed {
        logic [DATA_W-1:0]      result;
        logic [IDX_FIELD_W-1:0] dest;
        logic                   wrote;
        logic [STATUS_W-1:0]    status;
        logic                   ovf;
        logic [DATA_W-1:0]      next_pc;
    } exec_result_t;

    typedef struct {
        instr_t       ins;
        bit           known;
        exec_result_t exp;
    } directed_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // action, src_a, src_b, dest, shift_amount, load_value
    logic [55:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // result, dest_out, wrote, status, overflow, next_pc, zero padding
    logic [79:0] m_axis_tdata;

    // Shadow copy of the architectural state
    logic [DATA_W-1:0] shadow_regs [32];
    logic [DATA_W-1:0] shadow_pc;

    exec_result_t  awaited_results [$];
    directed_row_t directed_rows [$];

    bit calm      = 1'b0;
    int n_errors  = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_ovf     = 0;
    int n_skip    = 0;
    int n_jumps   = 0;
    int n_cycles  = 0;

    rtype_alu_execute DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Predict one instruction and update the shadow state
    function automatic exec_result_t execute_rtype(input instr_t ins);
        exec_result_t r;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] neg_b;
        logic [DATA_W-1:0] value;
        logic writes;
        logic ovf;
        a      = shadow_regs[ins.src_a];
        b      = shadow_regs[ins.src_b];
        neg_b  = '0 - b;
        value  = '0;
        writes = 1'b1;
        ovf    = 1'b0;
        case (ins.action)
            ACT_NOR:  value = ~(a | b);
            ACT_OR:   value = a | b;
            ACT_XOR:  value = a ^ b;
            ACT_AND:  value = a & b;
            ACT_NAND: value = ~(a & b);
            ACT_SLT:  value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            ACT_JR:
            begin
                shadow_pc = a;
                writes    = 1'b0;
            end
            ACT_SLL:  value = b << ins.shamt;
            ACT_SRL:  value = b >> ins.shamt;
            ACT_SRA:  value = $signed(b) >>> ins.shamt;
            ACT_ADD:
            begin
                value = a + b;
                ovf   = (a[31] == b[31]) && (value[31] != a[31]);
            end
            ACT_SUB:
            begin
                // the most negative subtrahend is always flagged
                value = a - b;
                ovf   = (b == SUB_OVF_VALUE) ||
                        ((a[31] == neg_b[31]) && (value[31] != a[31]));
            end
            ACT_LOAD: value = ins.load_value;
            default:  writes = 1'b0;
        endcase
        r.result = value;
        r.dest   = ins.dest;
        r.wrote  = 1'b0;
        r.status = STAT_NORMAL;
        r.ovf    = ovf;
        if (writes)
        begin
            if (ins.dest == '0)
                r.status = STAT_SKIP_ZERO;
            else
            begin
                if (ovf)
                    r.status = STAT_OVERFLOW;
                shadow_regs[ins.dest] = value;
                r.wrote = 1'b1;
            end
        end
        r.next_pc = shadow_pc;
        return r;
    endfunction

    task automatic add_row(input logic [ACT_W-1:0] act, input logic [4:0] ra, input logic [4:0] rb,
                           input logic [4:0] rd, input logic [4:0] sh, input logic [31:0] lv);
        directed_row_t row;
        row.ins   = '{load_value: lv, shamt: sh, dest: rd, src_b: rb, src_a: ra, action: act};
        row.known = 1'b0;
        row.exp   = '0;
        directed_rows.push_back(row);
    endtask

    // Row whose outcome is obvious enough to type in
    task automatic add_known(input logic [ACT_W-1:0] act, input logic [4:0] ra,
                             input logic [4:0] rb, input logic [4:0] rd, input logic [31:0] lv,
                             input logic [31:0] res, input logic w, input logic [1:0] st,
                             input logic ov, input logic [31:0] pc);
        directed_row_t row;
        row.ins   = '{load_value: lv, shamt: '0, dest: rd, src_b: rb, src_a: ra, action: act};
        row.known = 1'b1;
        row.exp   = '{result: res, dest: rd, wrote: w, status: st, ovf: ov, next_pc: pc};
        directed_rows.push_back(row);
    endtask

    // Favour low registers so that back-to-back dependencies are common
    function automatic logic [4:0] pick_reg();
        return $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
    endfunction

    function automatic instr_t random_instr();
        instr_t ins;
        int     roll;
        roll           = $urandom_range(0, 99);
        ins.src_a      = pick_reg();
        ins.src_b      = pick_reg();
        ins.dest       = ($urandom_range(0, 9) == 0) ? 5'd0 : pick_reg();
        ins.shamt      = 5'($urandom_range(0, 31));
        ins.load_value = $urandom;
        if (roll < 25)
        begin
            ins.action = ACT_LOAD;
            case ($urandom_range(0, 6))
                0: ins.load_value = '0;
                1: ins.load_value = 32'd1;
                2: ins.load_value = 32'h7FFF_FFFF;
                3: ins.load_value = SUB_OVF_VALUE;
                4: ins.load_value = '1;
                default: ;
            endcase
        end
        else if (roll < 95)
            ins.action = ACT_W'($urandom_range(ACT_NOR, ACT_SUB));
        else
            ins.action = ACT_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
        return ins;
    endfunction

    // Offer one request, then log its expected result on acceptance
    task automatic send_request(input instr_t ins, input bit known, input exec_result_t typed);
        exec_result_t predicted;
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ins;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = execute_rtype(ins);
        awaited_results.push_back(known ? typed : predicted);
        n_sent++;
        if (ins.action == ACT_JR)
            n_jumps++;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
            n_errors++;
        end
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Compare each delivered result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        exec_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t ns: unexpected result %h", $time, m_axis_tdata);
                n_errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("result", want.result, m_axis_tdata[31:0]);
                check_field("dest_out", 32'(want.dest), 32'(m_axis_tdata[36:32]));
                check_field("wrote", 32'(want.wrote), 32'(m_axis_tdata[37]));
                check_field("status", 32'(want.status), 32'(m_axis_tdata[39:38]));
                check_field("overflow", 32'(want.ovf), 32'(m_axis_tdata[40]));
                check_field("next_pc", want.next_pc, m_axis_tdata[72:41]);
                check_field("padding", 32'd0, 32'(m_axis_tdata[79:73]));
                n_checked++;
                if (want.ovf)
                    n_ovf++;
                if (want.status == STAT_SKIP_ZERO)
                    n_skip++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("%0t ns: timed out with %0d results outstanding", $time,
                     awaited_results.size());
            $display("[rtype_alu_execute] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        directed_row_t row;
        shadow_pc = '0;
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;

        // Registers all read as zero straight after reset
        add_known(ACT_OR,   1, 2, 3, 0,             0,             1, STAT_NORMAL,    0, 0);
        add_known(ACT_LOAD, 0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, STAT_NORMAL,    0, 0);
        add_known(ACT_LOAD, 0, 0, 2, 32'd1,         32'd1,         1, STAT_NORMAL,    0, 0);
        add_known(ACT_LOAD, 0, 0, 4, SUB_OVF_VALUE, SUB_OVF_VALUE, 1, STAT_NORMAL,    0, 0);
        add_known(ACT_LOAD, 0, 0, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STAT_NORMAL,    0, 0);
        // register zero is never written
        add_known(ACT_LOAD, 0, 0, 0, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 0, STAT_SKIP_ZERO, 0, 0);
        // overflow still writes; with dest zero the skip status wins
        add_known(ACT_ADD,  1, 2, 3, 0,             SUB_OVF_VALUE, 1, STAT_OVERFLOW,  1, 0);
        add_known(ACT_ADD,  4, 4, 0, 0,             0,             0, STAT_SKIP_ZERO, 1, 0);
        // most negative subtrahend flags overflow even when the result fits
        add_known(ACT_SUB,  5, 4, 6, 0,             32'h7FFF_FFFF, 1, STAT_OVERFLOW,  1, 0);
        add_row(ACT_SUB,  4, 2, 7,  0,  0);
        add_row(ACT_SUB,  2, 5, 8,  0,  0);
        add_row(ACT_SLT,  4, 1, 9,  0,  0);
        add_row(ACT_SLT,  1, 5, 10, 0,  0);
        add_row(ACT_SRA,  0, 4, 11, 31, 0);
        add_row(ACT_SRA,  0, 1, 12, 0,  0);
        add_row(ACT_SRL,  0, 5, 13, 31, 0);
        add_row(ACT_SLL,  0, 5, 14, 31, 0);
        add_row(ACT_NOR,  1, 4, 15, 0,  0);
        add_row(ACT_NAND, 5, 5, 16, 0,  0);
        add_row(ACT_XOR,  1, 5, 17, 0,  0);
        add_row(ACT_AND,  5, 1, 18, 0,  0);
        // jump register and the unused codes leave the file alone
        add_known(ACT_JR, 1, 0, 31, 0, 0, 0, STAT_NORMAL, 0, 32'h7FFF_FFFF);
        add_known(ACT_FIRST_UNUSED, 1, 1, 31, 32'hFFFF_FFFF, 0, 0, STAT_NORMAL, 0, 32'h7FFF_FFFF);
        add_known(ACT_LAST_UNUSED,  2, 2, 0,  32'hFFFF_FFFF, 0, 0, STAT_NORMAL, 0, 32'h7FFF_FFFF);
        add_row(ACT_LOAD, 0, 0, 31, 31, 32'hA5A5_A5A5);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        while (directed_rows.size() != 0)
        begin
            row = directed_rows.pop_front();
            send_request(row.ins, row.known, row.exp);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= CALM_FIRST) && (i < CALM_LAST);
            send_request(random_instr(), 1'b0, '0);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d jumps), checked %0d results: %0d overflows, %0d skipped",
                 n_sent, n_jumps, n_checked, n_ovf, n_skip);
        $display("writes to register zero; %0d field mismatches or stray results", n_errors);
        if (n_errors == 0)
            $display("[rtype_alu_execute] OK");
        else
            $display("[rtype_alu_execute] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rae_pkg.sv
rtl/core/rae_regfile.sv
rtl/core/rae_alu.sv
rtl/core/rtype_alu_execute.sv
bench/tb_rtype_alu_execute.sv
